@@ src/mhv_pkg.sv @@
// Shared types and constants for the metadata header validator.
// Used by mhv_check and by the top level metadata_header_validator.
// No dependencies.
package mhv_pkg;

    // Record sizes in bytes.
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned ENTRY_BYTES  = 24;
    localparam int unsigned POS_W        = 5;

    // Record kinds, as carried on the input and result tuser.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_ENTRY  = 1'b1;

    // Header constants. The magic is stored with byte 0 in the low bits.
    localparam logic [31:0] HEADER_MAGIC     = 32'h444D4143;
    localparam logic [7:0]  ENDIAN_LITTLE    = 8'd1;
    localparam logic [7:0]  ENDIAN_BIG       = 8'd2;
    localparam logic [7:0]  VERSION_CURRENT  = 8'd1;
    localparam logic [47:0] MIN_BINARY_SIZE  = 48'd16;
    localparam logic [31:0] MIN_LIST_OFFSET  = 32'd16;

    // Widths of the data and configuration words.
    localparam int unsigned BIN_SIZE_W = 48;
    localparam int unsigned MIN_OFF_W  = 37;
    localparam int unsigned M_DATA_W   = 296;

    typedef enum logic [1:0] {
        REG_BINARY_SIZE    = 2'd0,
        REG_ENCODING_LIMIT = 2'd1,
        REG_FORMAT_LIMIT   = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_SMALL    = 4'd1,
        ST_MAGIC    = 4'd2,
        ST_ENDIAN   = 4'd3,
        ST_VERSION  = 4'd4,
        ST_LISTOFF  = 4'd5,
        ST_BLKOFF   = 4'd6,
        ST_BLKSIZE  = 4'd7,
        ST_NAME     = 4'd8,
        ST_FLAGS    = 4'd9,
        ST_NOHEADER = 4'd10
    } status_t;

    // Record bytes, byte 0 in the low bits.
    typedef logic [ENTRY_BYTES-1:0][7:0] record_t;

    typedef struct packed {
        logic [BIN_SIZE_W-1:0] binary_size;
        logic [7:0]            encoding_limit;
        logic [7:0]            format_limit;
    } mhv_cfg_t;

    // Context left behind by the last header.
    typedef struct packed {
        logic                 header_ok;
        logic                 big_endian;
        logic [31:0]          list_offset;
        logic [31:0]          block_count;
        logic [MIN_OFF_W-1:0] min_offset;
        logic [31:0]          entry_count;
    } mhv_ctx_t;

    // State changes requested by a finished record.
    typedef struct packed {
        logic                 header_done;
        logic                 header_accept;
        logic                 big_endian;
        logic [31:0]          list_offset;
        logic [31:0]          block_count;
        logic [MIN_OFF_W-1:0] min_offset;
        logic                 entry_inc;
    } mhv_update_t;

    typedef struct packed {
        logic        record_kind;
        status_t     status;
        logic [31:0] list_offset;
        logic [31:0] block_count;
        logic        is_big_endian;
        logic [63:0] block_offset;
        logic [63:0] block_length;
        logic [31:0] name_index;
        logic [31:0] flag_word;
        logic [31:0] entry_number;
    } mhv_result_t;

endpackage

@@ src/mhv_check.sv @@
// Record checker for the metadata header validator: decodes a finished record
// and produces its result and the header state update. Purely combinational.
// Depends on mhv_pkg.
module mhv_check
    import mhv_pkg::*;
(
    input  record_t     rec,
    input  logic        kind,
    input  mhv_ctx_t    ctx,
    input  mhv_cfg_t    cfg,
    output mhv_result_t result,
    output mhv_update_t update
);

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        logic [31:0] y;
        for (int i = 0; i < 4; i++) begin
            y[8*i +: 8] = x[8*(3-i) +: 8];
        end
        return y;
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 8; i++) begin
            y[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return y;
    endfunction

    // Header decode.
    logic                 hdr_big;
    logic [31:0]          hdr_lo;
    logic [31:0]          hdr_cnt;
    logic [MIN_OFF_W-1:0] hdr_min_off;
    status_t              hdr_status;

    // Entry decode.
    logic [63:0] ent_off;
    logic [63:0] ent_len;
    logic [31:0] ent_name;
    logic [31:0] ent_flags;
    logic [64:0] ent_sum;
    status_t     ent_status;

    always_comb begin
        hdr_big = (rec[4] == ENDIAN_BIG);
        hdr_lo  = hdr_big ? bswap32(rec[11:8])  : rec[11:8];
        hdr_cnt = hdr_big ? bswap32(rec[15:12]) : rec[15:12];
        // First valid entry offset: list offset plus 24 bytes per entry.
        hdr_min_off = {5'd0, hdr_lo} + {1'b0, hdr_cnt, 4'd0} + {2'd0, hdr_cnt, 3'd0};

        priority if (cfg.binary_size < MIN_BINARY_SIZE) begin
            hdr_status = ST_SMALL;
        end else if (rec[3:0] != HEADER_MAGIC) begin
            hdr_status = ST_MAGIC;
        end else if (rec[4] != ENDIAN_LITTLE && rec[4] != ENDIAN_BIG) begin
            hdr_status = ST_ENDIAN;
        end else if (rec[5] != VERSION_CURRENT) begin
            hdr_status = ST_VERSION;
        end else if (hdr_lo < MIN_LIST_OFFSET ||
                     {16'd0, hdr_lo} >= cfg.binary_size) begin
            hdr_status = ST_LISTOFF;
        end else begin
            hdr_status = ST_OK;
        end
    end

    always_comb begin
        ent_off   = ctx.big_endian ? bswap64(rec[7:0])   : rec[7:0];
        ent_len   = ctx.big_endian ? bswap64(rec[15:8])  : rec[15:8];
        ent_name  = ctx.big_endian ? bswap32(rec[19:16]) : rec[19:16];
        ent_flags = ctx.big_endian ? bswap32(rec[23:20]) : rec[23:20];
        // A carry out of 64 bits lands in bit 64 and exceeds any binary size.
        ent_sum   = {1'b0, ent_off} + {1'b0, ent_len};

        priority if (!ctx.header_ok) begin
            ent_status = ST_NOHEADER;
        end else if ({27'd0, ctx.min_offset} > ent_off) begin
            ent_status = ST_BLKOFF;
        end else if (ent_sum > {17'd0, cfg.binary_size}) begin
            ent_status = ST_BLKSIZE;
        end else if (ent_name > ctx.list_offset) begin
            ent_status = ST_NAME;
        end else if (!(ent_flags[15:8] < cfg.encoding_limit ||
                       ent_flags[7:0] < cfg.format_limit)) begin
            ent_status = ST_FLAGS;
        end else begin
            ent_status = ST_OK;
        end
    end

    always_comb begin
        result = '0;
        update = '0;
        update.big_endian  = hdr_big;
        update.list_offset = hdr_lo;
        update.block_count = hdr_cnt;
        update.min_offset  = hdr_min_off;
        if (kind == KIND_HEADER) begin
            result.record_kind  = KIND_HEADER;
            result.status       = hdr_status;
            update.header_done  = 1'b1;
            if (hdr_status == ST_OK) begin
                update.header_accept = 1'b1;
                result.list_offset   = hdr_lo;
                result.block_count   = hdr_cnt;
                result.is_big_endian = hdr_big;
            end
        end else begin
            result.record_kind = KIND_ENTRY;
            result.status      = ent_status;
            if (ctx.header_ok) begin
                update.entry_inc     = 1'b1;
                result.list_offset   = ctx.list_offset;
                result.block_count   = ctx.block_count;
                result.is_big_endian = ctx.big_endian;
                result.block_offset  = ent_off;
                result.block_length  = ent_len;
                result.name_index    = ent_name;
                result.flag_word     = ent_flags;
                result.entry_number  = ctx.entry_count;
            end
        end
    end

endmodule

@@ src/metadata_header_validator.sv @@
// Top level of the metadata header validator: byte assembly, header context,
// configuration registers and the result register.
// Depends on mhv_pkg and mhv_check.
//
//   Channel  | Direction | Item                       | Fields (tuser / tdata)
//   ---------+-----------+----------------------------+--------------------------------
//   s_       | in        | one record byte            | op / data_byte
//   m_       | out       | one checked record         | record_kind / status..entry_number
//   cfg_     | in        | one register write         | index / value (no handshake)
//
// One byte is taken per cycle while s_tready is high. When the last byte of a
// record (16 for a header, 24 for a block entry) is accepted, the assembled bytes
// are registered, the checker runs on them combinationally and its result is
// loaded into the output register when it is free. Input stalls only when a
// finished record waits for the checker while the output register still holds
// an untaken result. Reset is synchronous and active low; it clears the byte
// position, the header state and the output valid, and sets the limits to one.
module metadata_header_validator
    import mhv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input bytes.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic [0:0]            s_tuser,   // [0] op
    // Results.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] status, [35:4] list_offset, [67:36] block_count, [68] is_big_endian,
    // [132:69] block_offset, [196:133] block_length, [228:197] name_index,
    // [260:229] flag_word, [292:261] entry_number, [295:293] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic [0:0]            m_tuser,   // [0] record_kind
    // Configuration writes.
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [BIN_SIZE_W-1:0] cfg_wdata
);

    // Byte assembly.
    record_t              rec_reg, rec_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 kind_reg, kind_next;
    logic                 done_reg, done_next;

    // Header context.
    mhv_ctx_t             ctx_reg, ctx_next;

    // Configuration.
    mhv_cfg_t             cfg_reg, cfg_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    mhv_result_t          m_result_reg, m_result_next;

    logic                 s_fire;
    logic                 out_free;
    logic                 check_fire;
    logic [POS_W-1:0]     pos_eff;
    logic [POS_W-1:0]     pos_last;
    logic                 byte_last;
    mhv_result_t          chk_result;
    mhv_update_t          chk_update;

    mhv_check u_check (
        .rec    (rec_reg),
        .kind   (kind_reg),
        .ctx    (ctx_reg),
        .cfg    (cfg_reg),
        .result (chk_result),
        .update (chk_update)
    );

    // The output register is free when empty or being drained this cycle.
    assign out_free   = !m_valid_reg || m_tready;
    // The checker result moves into the output register when there is room.
    assign check_fire = done_reg && out_free;
    // While a finished record waits, its bytes must not be overwritten.
    assign s_tready   = !done_reg || out_free;
    assign s_fire     = s_tvalid && s_tready;

    // A change of op drops any partial record and starts over.
    always_comb begin
        pos_eff   = (s_tuser[0] != kind_reg) ? '0 : pos_reg;
        pos_last  = (s_tuser[0] == KIND_ENTRY) ? POS_W'(ENTRY_BYTES - 1)
                                               : POS_W'(HEADER_BYTES - 1);
        byte_last = (pos_eff == pos_last);
    end

    always_comb begin
        rec_next  = rec_reg;
        pos_next  = pos_reg;
        kind_next = kind_reg;
        done_next = done_reg;
        if (check_fire) begin
            done_next = 1'b0;
        end
        if (s_fire) begin
            rec_next[pos_eff] = s_tdata;
            kind_next         = s_tuser[0];
            pos_next          = byte_last ? '0 : pos_eff + POS_W'(1);
            if (byte_last) begin
                done_next = 1'b1;
            end
        end
    end

    // Header context follows the record that just went through the checker.
    always_comb begin
        ctx_next = ctx_reg;
        if (check_fire) begin
            if (chk_update.header_done) begin
                ctx_next.header_ok = chk_update.header_accept;
                if (chk_update.header_accept) begin
                    ctx_next.big_endian  = chk_update.big_endian;
                    ctx_next.list_offset = chk_update.list_offset;
                    ctx_next.block_count = chk_update.block_count;
                    ctx_next.min_offset  = chk_update.min_offset;
                    ctx_next.entry_count = '0;
                end
            end else if (chk_update.entry_inc) begin
                ctx_next.entry_count = ctx_reg.entry_count + 32'd1;
            end
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_BINARY_SIZE:    cfg_next.binary_size    = cfg_wdata;
                REG_ENCODING_LIMIT: cfg_next.encoding_limit = cfg_wdata[7:0];
                REG_FORMAT_LIMIT:   cfg_next.format_limit   = cfg_wdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_result_next = m_result_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (check_fire) begin
            m_valid_next  = 1'b1;
            m_result_next = chk_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg                 <= '0;
            kind_reg                <= KIND_HEADER;
            done_reg                <= 1'b0;
            ctx_reg                 <= '0;
            cfg_reg.binary_size     <= '0;
            cfg_reg.encoding_limit  <= 8'd1;
            cfg_reg.format_limit    <= 8'd1;
            m_valid_reg             <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            kind_reg    <= kind_next;
            done_reg    <= done_next;
            ctx_reg     <= ctx_next;
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg      <= rec_next;
        m_result_reg <= m_result_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = m_result_reg.record_kind;
    assign m_tdata    = {3'd0,
                         m_result_reg.entry_number,
                         m_result_reg.flag_word,
                         m_result_reg.name_index,
                         m_result_reg.block_length,
                         m_result_reg.block_offset,
                         m_result_reg.is_big_endian,
                         m_result_reg.block_count,
                         m_result_reg.list_offset,
                         m_result_reg.status};

endmodule

@@ src/mhv_checker.sv @@
// Port-level assertions for metadata_header_validator, attached by bind.
// Depends on mhv_pkg and on the top level's result port layout.
module mhv_checker
    import mhv_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A header result never carries block entry fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_HEADER |-> m_tdata[M_DATA_W-1:69] == '0)
        else $error("header result with entry fields");

    // A rejected header reports no decoded header fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_HEADER && m_tdata[3:0] != ST_OK
        |-> m_tdata[68:4] == '0)
        else $error("rejected header with decoded fields");

    // The missing-header status only comes with an empty block entry result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] == ST_NOHEADER
        |-> m_tuser[0] == KIND_ENTRY && m_tdata[M_DATA_W-1:4] == '0)
        else $error("malformed no-header result");

endmodule

bind metadata_header_validator mhv_checker u_mhv_checker (.*);

@@ sim/metadata_header_validator_test.sv @@
// Self-checking testbench for metadata_header_validator: byte streams of headers and block
// entries are checked against a built-in predictor of the record checks.
// Depends on mhv_pkg and the metadata_header_validator RTL.
module metadata_header_validator_test;
    import mhv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 8;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam logic [BIN_SIZE_W-1:0] MAX_BIN_SIZE = '1;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_we;
    logic [1:0]            cfg_addr;
    logic [BIN_SIZE_W-1:0] cfg_wdata;

    // Predictor state: the record being assembled and the context of the last header.
    record_t               asm_bytes;
    int                    asm_pos;
    logic                  asm_kind;
    logic                  hdr_valid;
    logic                  hdr_big;
    logic [31:0]           hdr_list_off;
    logic [31:0]           hdr_block_cnt;
    logic [31:0]           entry_count;

    // Predictor copy of the configuration registers.
    logic [BIN_SIZE_W-1:0] cfg_bin_size;
    logic [7:0]            cfg_enc_limit;
    logic [7:0]            cfg_fmt_limit;

    // Results predicted but not yet seen on the result channel, oldest first.
    mhv_result_t           pending_results[$];
    mhv_result_t           got_result;
    mhv_result_t           want_result;

    // Idling controls, switched by the test tasks.
    bit                    send_gaps;
    bit                    ready_stalls;
    int                    ready_hold;

    // Bookkeeping for the summary and the verdict.
    int                    error_count;
    int                    bytes_sent;
    int                    results_predicted;
    int                    headers_checked;
    int                    entries_checked;
    int                    settings_used;
    logic [15:0]           status_seen;

    metadata_header_validator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Mostly back-to-back, often a short pause, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Reads a multi-byte field of the assembled record in the given byte order.
    function automatic logic [63:0] decode_field(int at, int len, logic big);
        logic [63:0] v;
        int idx;
        v = '0;
        for (int i = 0; i < len; i++) begin
            idx = big ? at + i : at + len - 1 - i;
            v = {v[55:0], asm_bytes[idx]};
        end
        return v;
    endfunction

    // Header checks run in a fixed order and the first failure wins. Only an
    // accepted header touches the stored context; a rejected one just drops it.
    function automatic mhv_result_t check_header();
        mhv_result_t res;
        logic        big;
        logic [31:0] lo;
        logic [31:0] cnt;
        res = '0;
        res.record_kind = KIND_HEADER;
        big = (asm_bytes[4] == ENDIAN_BIG);
        lo  = 32'(decode_field(8, 4, big));
        cnt = 32'(decode_field(12, 4, big));
        if (cfg_bin_size < MIN_BINARY_SIZE) begin
            res.status = ST_SMALL;
        end else if (asm_bytes[3:0] != HEADER_MAGIC) begin
            res.status = ST_MAGIC;
        end else if (asm_bytes[4] != ENDIAN_LITTLE && asm_bytes[4] != ENDIAN_BIG) begin
            res.status = ST_ENDIAN;
        end else if (asm_bytes[5] != VERSION_CURRENT) begin
            res.status = ST_VERSION;
        end else if (lo < MIN_LIST_OFFSET || lo >= cfg_bin_size) begin
            res.status = ST_LISTOFF;
        end else begin
            res.status = ST_OK;
        end
        if (res.status == ST_OK) begin
            hdr_valid     = 1'b1;
            hdr_big       = big;
            hdr_list_off  = lo;
            hdr_block_cnt = cnt;
            entry_count   = '0;
            res.list_offset   = lo;
            res.block_count   = cnt;
            res.is_big_endian = big;
        end else begin
            hdr_valid = 1'b0;
        end
        return res;
    endfunction

    // Block entries are decoded in the byte order of the last accepted header.
    // The offset+size sum is kept one bit wider so a carry counts as too large.
    function automatic mhv_result_t check_entry();
        mhv_result_t res;
        logic [63:0] min_off;
        logic [64:0] total;
        res = '0;
        res.record_kind = KIND_ENTRY;
        if (!hdr_valid) begin
            res.status = ST_NOHEADER;
            return res;
        end
        res.list_offset   = hdr_list_off;
        res.block_count   = hdr_block_cnt;
        res.is_big_endian = hdr_big;
        res.block_offset  = decode_field(0, 8, hdr_big);
        res.block_length  = decode_field(8, 8, hdr_big);
        res.name_index    = 32'(decode_field(16, 4, hdr_big));
        res.flag_word     = 32'(decode_field(20, 4, hdr_big));
        res.entry_number  = entry_count;
        min_off = {32'd0, hdr_list_off} + 64'(ENTRY_BYTES) * {32'd0, hdr_block_cnt};
        total   = {1'b0, res.block_offset} + {1'b0, res.block_length};
        if (res.block_offset < min_off) begin
            res.status = ST_BLKOFF;
        end else if (total > {17'd0, cfg_bin_size}) begin
            res.status = ST_BLKSIZE;
        end else if (res.name_index > hdr_list_off) begin
            res.status = ST_NAME;
        end else if (!(res.flag_word[15:8] < cfg_enc_limit ||
                       res.flag_word[7:0] < cfg_fmt_limit)) begin
            res.status = ST_FLAGS;
        end else begin
            res.status = ST_OK;
        end
        entry_count = entry_count + 32'd1;
        return res;
    endfunction

    // Appends one prediction at the young end of the waiting list.
    task automatic queue_result(mhv_result_t res);
        pending_results = {pending_results, res};
        results_predicted++;
    endtask

    // Takes one accepted byte. A change of kind throws away a partial record.
    task automatic assemble_byte(logic op, logic [7:0] value);
        int need;
        if (op != asm_kind) begin
            asm_kind = op;
            asm_pos  = 0;
        end
        need = (op == KIND_ENTRY) ? ENTRY_BYTES : HEADER_BYTES;
        if (asm_pos >= need) asm_pos = 0;
        asm_bytes[asm_pos] = value;
        asm_pos++;
        if (asm_pos == need) begin
            asm_pos = 0;
            if (op == KIND_ENTRY) queue_result(check_entry());
            else queue_result(check_header());
        end
    endtask

    // ------------------------------------------------------------------
    // Record builders for the stimulus
    // ------------------------------------------------------------------

    function automatic record_t put_field(record_t r, int at, int len, logic [63:0] v,
                                          logic big);
        for (int i = 0; i < len; i++) begin
            r[big ? at + len - 1 - i : at + i] = v[8*i +: 8];
        end
        return r;
    endfunction

    function automatic record_t random_bytes();
        record_t r;
        for (int i = 0; i < ENTRY_BYTES; i++) r[i] = 8'($urandom);
        return r;
    endfunction

    function automatic record_t make_header(logic [31:0] magic, logic [7:0] endian,
                                            logic [7:0] version, logic [31:0] lo,
                                            logic [31:0] cnt);
        record_t r;
        r = random_bytes();
        r[3:0] = magic;
        r[4] = endian;
        r[5] = version;
        r = put_field(r, 8, 4, lo, endian == ENDIAN_BIG);
        r = put_field(r, 12, 4, cnt, endian == ENDIAN_BIG);
        return r;
    endfunction

    // Entries are laid out in the byte order the current header declared.
    function automatic record_t make_entry(logic [63:0] off, logic [63:0] len,
                                           logic [31:0] name, logic [31:0] flags);
        record_t r;
        r = put_field('0, 0, 8, off, hdr_big);
        r = put_field(r, 8, 8, len, hdr_big);
        r = put_field(r, 16, 4, name, hdr_big);
        r = put_field(r, 20, 4, flags, hdr_big);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge where it is taken. tvalid stays high
    // afterwards so that a following item can go out with no bubble; anything that
    // holds the sender back lowers it first.
    task automatic send_byte(logic op, logic [7:0] value);
        int gap;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        assemble_byte(op, value);
    endtask

    task automatic send_record(logic op, record_t r, int count);
        for (int i = 0; i < count; i++) send_byte(op, r[i]);
    endtask

    task automatic send_header(logic [31:0] magic, logic [7:0] endian, logic [7:0] version,
                               logic [31:0] lo, logic [31:0] cnt);
        send_record(KIND_HEADER, make_header(magic, endian, version, lo, cnt), HEADER_BYTES);
    endtask

    task automatic send_entry(logic [63:0] off, logic [63:0] len, logic [31:0] name,
                              logic [31:0] flags);
        send_record(KIND_ENTRY, make_entry(off, len, name, flags), ENTRY_BYTES);
    endtask

    // Holds the sender until every predicted result is out, then lets the
    // checker pipeline run dry, since a partial record gives no result to wait on.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One register write, then the enable is lowered before returning, so back-to-back writes never
    // raise and lower the enable in the same step.
    task automatic write_reg(cfg_index_t index, logic [BIN_SIZE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            REG_BINARY_SIZE:    cfg_bin_size  = value;
            REG_ENCODING_LIMIT: cfg_enc_limit = value[7:0];
            REG_FORMAT_LIMIT:   cfg_fmt_limit = value[7:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(logic [BIN_SIZE_W-1:0] size, logic [7:0] enc_limit,
                                  logic [7:0] fmt_limit);
        wait_for_results();
        write_reg(REG_BINARY_SIZE, size);
        write_reg(REG_ENCODING_LIMIT, {40'd0, enc_limit});
        write_reg(REG_FORMAT_LIMIT, {40'd0, fmt_limit});
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (ready_stalls && $urandom_range(0, 5) == 0) begin
            ready_hold = pick_gap() + 1;
        end
        m_tready <= (ready_hold == 0);
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Every accepted result is compared against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.record_kind   = m_tuser[0];
            got_result.status        = status_t'(m_tdata[3:0]);
            got_result.list_offset   = m_tdata[35:4];
            got_result.block_count   = m_tdata[67:36];
            got_result.is_big_endian = m_tdata[68];
            got_result.block_offset  = m_tdata[132:69];
            got_result.block_length  = m_tdata[196:133];
            got_result.name_index    = m_tdata[228:197];
            got_result.flag_word     = m_tdata[260:229];
            got_result.entry_number  = m_tdata[292:261];
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with no prediction waiting: expected none, got %h",
                         $time, got_result);
            end else begin
                want_result = pending_results.pop_front();
                check_field("record_kind", 64'(want_result.record_kind),
                            64'(got_result.record_kind));
                check_field("status", 64'(want_result.status), 64'(got_result.status));
                check_field("list_offset", 64'(want_result.list_offset),
                            64'(got_result.list_offset));
                check_field("block_count", 64'(want_result.block_count),
                            64'(got_result.block_count));
                check_field("is_big_endian", 64'(want_result.is_big_endian),
                            64'(got_result.is_big_endian));
                check_field("block_offset", want_result.block_offset,
                            got_result.block_offset);
                check_field("block_length", want_result.block_length,
                            got_result.block_length);
                check_field("name_index", 64'(want_result.name_index),
                            64'(got_result.name_index));
                check_field("flag_word", 64'(want_result.flag_word),
                            64'(got_result.flag_word));
                check_field("entry_number", 64'(want_result.entry_number),
                            64'(got_result.entry_number));
                if (want_result.record_kind == KIND_HEADER) headers_checked++;
                else entries_checked++;
                status_seen[want_result.status] = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset the binary size is zero, so no header can pass and
    // any block entry finds no valid header in front of it.
    task automatic test_reset_defaults();
        send_entry(64'h10, 64'h20, 32'h0, 32'h0);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT, 32'd16, 32'd1);
    endtask

    // Each header check in turn, including both edges of the list offset window
    // and binary sizes right at the minimum.
    task automatic test_header_checks();
        apply_settings(48'd15, 8'd1, 8'd1);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT, 32'd16, 32'd0);
        apply_settings(48'd16, 8'd1, 8'd1);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT, 32'd16, 32'd0);
        apply_settings(48'h1000, 8'd1, 8'd1);
        send_header(HEADER_MAGIC ^ 32'h8000_0000, ENDIAN_LITTLE, VERSION_CURRENT, 32'd16, 32'd0);
        send_header(HEADER_MAGIC ^ 32'h0000_0001, ENDIAN_BIG, VERSION_CURRENT, 32'd16, 32'd0);
        send_header(HEADER_MAGIC, 8'd0, VERSION_CURRENT, 32'd16, 32'd0);
        send_header(HEADER_MAGIC, 8'hff, VERSION_CURRENT, 32'd16, 32'd0);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, 8'd0, 32'd16, 32'd0);
        send_header(HEADER_MAGIC, ENDIAN_BIG, 8'hff, 32'd16, 32'd0);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT, 32'd15, 32'd0);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT, 32'h1000, 32'd0);
        send_header(HEADER_MAGIC, ENDIAN_BIG, VERSION_CURRENT, 32'hfff, 32'hffff_ffff);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT, 32'd16, 32'd3);
    endtask

    // Each block entry check, with offsets and sizes right at their bounds and a
    // sum that carries out of 64 bits.
    task automatic test_entry_checks();
        apply_settings(MAX_BIN_SIZE, 8'd1, 8'd1);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT, 32'h100, 32'd2);
        send_entry(64'h12f, 64'h0, 32'h0, 32'h0);
        send_entry(64'h130, {16'd0, MAX_BIN_SIZE} - 64'h130, 32'h100, 32'h0);
        send_entry(64'h130, {16'd0, MAX_BIN_SIZE} - 64'h12f, 32'h0, 32'h0);
        send_entry('1, 64'h1, 32'h0, 32'h0);
        send_entry(64'h130, 64'h8, 32'h101, 32'h0);
        send_entry(64'h200, 64'h8, 32'h0, 32'h0000_0101);
        send_entry(64'h200, 64'h8, 32'h0, 32'h0000_0001);
        send_entry(64'h200, 64'h8, 32'h0, 32'hffff_0100);
        // Big-endian context with a list offset near the top of its range and the largest block count.
        send_header(HEADER_MAGIC, ENDIAN_BIG, VERSION_CURRENT, 32'hffff_fff0, 32'hffff_ffff);
        send_entry(64'hffff_fff0 + 64'(ENTRY_BYTES) * 64'hffff_ffff, 64'h0, 32'hffff_fff0,
                   32'hffff_ffff);
        send_entry(64'h0123_4567_89ab_cdef, 64'h0, 32'hffff_ffff, 32'h0);
    endtask

    // Switching kinds mid-record drops the partial bytes; the entry count carries
    // on across the interruption.
    task automatic test_kind_change();
        send_record(KIND_HEADER, make_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT,
                                             32'd16, 32'd0), 7);
        send_entry(64'h0123_4567_89ab_cdef, 64'h10, 32'h5, 32'h0);
        send_record(KIND_ENTRY, random_bytes(), 23);
        send_header(HEADER_MAGIC, ENDIAN_LITTLE, VERSION_CURRENT, 32'h40, 32'd1);
        send_entry(64'h58, 64'h10, 32'h40, 32'h0);
    endtask

    // A rejected header clears the valid context: entries report no header, and
    // the next good header restarts the entry count.
    task automatic test_header_rejection();
        send_header(HEADER_MAGIC, 8'd3, VERSION_CURRENT, 32'h40, 32'd1);
        send_entry(64'h58, 64'h10, 32'h0, 32'h0);
        send_header(HEADER_MAGIC, ENDIAN_BIG, VERSION_CURRENT, 32'h40, 32'd1);
        send_entry(64'h58, 64'h10, 32'h0, 32'h0);
        send_entry(64'h60, 64'h10, 32'h0, 32'h0);
    endtask

    // Mostly well-formed headers and entries with random content aimed near the
    // check boundaries, plus truncated records and raw noise.
    task automatic random_record();
        int          roll;
        int          count;
        logic        op;
        logic [31:0] lo;
        logic [31:0] lo_max;
        logic [31:0] cnt;
        logic [63:0] min_off;
        logic [63:0] off;
        logic [63:0] len;
        logic [31:0] name;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            op    = 1'($urandom_range(0, 1));
            count = $urandom_range(1, (op == KIND_ENTRY) ? ENTRY_BYTES - 1 : HEADER_BYTES - 1);
            send_record(op, random_bytes(), count);
        end else if (roll < 40) begin
            if (cfg_bin_size > 48'h1_0000_0000) lo_max = 32'hffff_ffff;
            else lo_max = 32'(cfg_bin_size) - 32'd1;
            if (cfg_bin_size > MIN_BINARY_SIZE && $urandom_range(0, 9) < 8)
                lo = $urandom_range(MIN_LIST_OFFSET, ($urandom_range(0, 1) == 0) ?
                                    lo_max : ((lo_max > 32'h1000) ? 32'h1000 : lo_max));
            else
                lo = $urandom;
            cnt = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 64) : $urandom;
            send_header(($urandom_range(0, 9) != 0) ? HEADER_MAGIC : $urandom,
                        ($urandom_range(0, 9) != 0) ? 8'($urandom_range(1, 2)) : 8'($urandom),
                        ($urandom_range(0, 9) != 0) ? VERSION_CURRENT : 8'($urandom),
                        lo, cnt);
        end else begin
            min_off = {32'd0, hdr_list_off} + 64'(ENTRY_BYTES) * {32'd0, hdr_block_cnt};
            off  = ($urandom_range(0, 3) != 0) ? min_off + $urandom_range(0, 255)
                                               : {$urandom, $urandom};
            len  = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(0, 4096))
                                              : {$urandom, $urandom};
            name = ($urandom_range(0, 9) < 7) ? $urandom_range(0, hdr_list_off) : $urandom;
            send_entry(off, len, name, $urandom);
        end
    endtask

    // A short burst of random records under one register setting.
    task automatic random_phase(logic [BIN_SIZE_W-1:0] size, logic [7:0] enc_limit,
                                logic [7:0] fmt_limit, bit gaps, bit stalls);
        int first_byte;
        apply_settings(size, enc_limit, fmt_limit);
        send_gaps    = gaps;
        ready_stalls = stalls;
        first_byte   = bytes_sent;
        while (bytes_sent - first_byte < 16) begin
            random_record();
            // Occasionally starve the block so it runs completely empty mid-phase.
            if ($urandom_range(0, 15) == 0) wait_for_results();
        end
    endtask

    task automatic test_random_traffic();
        random_phase(MAX_BIN_SIZE, 8'($urandom), 8'($urandom), 1'b0, 1'b0);
        random_phase('0, 8'd0, 8'd255, 1'b1, 1'b1);
        random_phase(48'($urandom_range(17, 1 << 20)), 8'd255, 8'd0, 1'b1, 1'b0);
        random_phase(MAX_BIN_SIZE, 8'd0, 8'd0, 1'b0, 1'b1);
        random_phase({16'($urandom), 32'($urandom)}, 8'($urandom), 8'($urandom), 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;

        // Predictor starts from the reset state of the block.
        asm_bytes     = '0;
        asm_pos       = 0;
        asm_kind      = KIND_HEADER;
        hdr_valid     = 1'b0;
        hdr_big       = 1'b0;
        hdr_list_off  = '0;
        hdr_block_cnt = '0;
        entry_count   = '0;
        cfg_bin_size  = '0;
        cfg_enc_limit = 8'd1;
        cfg_fmt_limit = 8'd1;
        send_gaps     = 1'b1;
        ready_stalls  = 1'b1;
        ready_hold    = 0;
        status_seen   = '0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_header_checks();
        test_entry_checks();
        test_kind_change();
        test_header_rejection();
        test_random_traffic();
        wait_for_results();

        $display("Summary: %0d bytes sent, %0d results predicted, %0d checked (%0d headers, %0d entries).",
                 bytes_sent, results_predicted, headers_checked + entries_checked,
                 headers_checked, entries_checked);
        $display("Summary: %0d of 11 status codes seen over %0d register settings.",
                 $countones(status_seen), settings_used);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
